[hdl/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked check, held off while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[hdl/aisc_pkg.sv]
// ----------------------------------------------------------------------------
// aisc_pkg
// types and constants of the audio interface sample counter
// ----------------------------------------------------------------------------
package aisc_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_EXT   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_CONTROL = 2'd0,
        REG_VOLUME  = 2'd1,
        REG_COUNTER = 2'd2,
        REG_TIMING  = 2'd3
    } t_reg;

    // configuration register indexes
    localparam logic [1:0] CFG_FAST = 2'd0;
    localparam logic [1:0] CFG_SLOW = 2'd1;

    localparam logic [15:0] PERIOD_FAST_RESET = 16'd10116;
    localparam logic [15:0] PERIOD_SLOW_RESET = 16'd15173;

    // control bit positions
    localparam int CB_PLAY  = 0;
    localparam int CB_SFR   = 1;
    localparam int CB_MASK  = 2;
    localparam int CB_INT   = 3;
    localparam int CB_VLD   = 4;
    localparam int CB_RESET = 5;
    localparam int CB_DFR   = 6;

    localparam logic [6:0] CTRL_RESET = 7'h02;
    // bits copied straight from a control write
    localparam logic [6:0] CTRL_KEEP  = 7'h56;

    localparam int PHASE_W = 17;

    typedef struct packed {
        t_cmd        cmd;
        t_reg        reg_index;
        logic [31:0] write_data;
    } t_item;

    typedef struct packed {
        logic [7:0]  volume_right;
        logic [7:0]  volume_left;
        logic        dma_rate_slow;
        logic        stream_rate_fast;
        logic        sample_strobe;
        logic        playing;
        logic        irq_line;
        logic [31:0] read_data;
    } t_result;

endpackage

[hdl/aisc_state.sv]
// ----------------------------------------------------------------------------
// aisc_state
// register state of the audio interface and its one-pass update per word
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aisc_state
    import aisc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_item       i_item,
    input  logic [15:0] i_period_fast,
    input  logic [15:0] i_period_slow,
    output t_result     o_result
);

    logic [6:0]         r_ctrl,  n_ctrl;
    logic [31:0]        r_vol,   n_vol;
    logic [31:0]        r_count, n_count;
    logic [31:0]        r_cmp,   n_cmp;
    logic [PHASE_W-1:0] r_phase, n_phase;

    logic [PHASE_W-1:0] phase_inc;
    logic [15:0]        period;
    logic [31:0]        rd;
    logic               strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl  <= CTRL_RESET;
            r_vol   <= '0;
            r_count <= '0;
            r_cmp   <= '0;
            r_phase <= '0;
        end else if (i_accept) begin
            r_ctrl  <= n_ctrl;
            r_vol   <= n_vol;
            r_count <= n_count;
            r_cmp   <= n_cmp;
            r_phase <= n_phase;
        end
    end

    assign period    = r_ctrl[CB_SFR] ? i_period_fast : i_period_slow;
    assign phase_inc = r_phase + PHASE_W'(1);

    always_comb begin
        n_ctrl  = r_ctrl;
        n_vol   = r_vol;
        n_count = r_count;
        n_cmp   = r_cmp;
        n_phase = r_phase;
        rd      = '0;
        strobe  = 1'b0;
        unique case (i_item.cmd)
            CMD_READ: begin
                unique case (i_item.reg_index)
                    REG_CONTROL: rd = {25'd0, r_ctrl};
                    REG_VOLUME:  rd = r_vol;
                    REG_COUNTER: rd = r_count;
                    REG_TIMING:  rd = r_cmp;
                    default:     rd = '0;
                endcase
            end
            CMD_WRITE: begin
                unique case (i_item.reg_index)
                    REG_CONTROL: begin
                        n_ctrl = (r_ctrl & ~CTRL_KEEP) | (i_item.write_data[6:0] & CTRL_KEEP);
                        if (i_item.write_data[CB_PLAY] != r_ctrl[CB_PLAY]) begin
                            n_ctrl[CB_PLAY] = i_item.write_data[CB_PLAY];
                            n_phase         = '0;
                        end
                        // write one to clear
                        if (i_item.write_data[CB_INT]) begin
                            n_ctrl[CB_INT] = 1'b0;
                        end
                        if (i_item.write_data[CB_RESET]) begin
                            n_count = '0;
                            n_phase = '0;
                        end
                        n_ctrl[CB_RESET] = 1'b0;
                    end
                    REG_VOLUME: n_vol = i_item.write_data;
                    REG_COUNTER: begin
                        n_count = i_item.write_data;
                        n_phase = '0;
                    end
                    REG_TIMING: n_cmp = i_item.write_data;
                    default: n_cmp = r_cmp;
                endcase
            end
            CMD_TICK: begin
                if (r_ctrl[CB_PLAY]) begin
                    // at most one sample per tick, a large phase drains over ticks
                    if (phase_inc > {1'b0, period}) begin
                        n_phase = phase_inc - {1'b0, period};
                        n_count = r_count + 32'd1;
                        strobe  = 1'b1;
                        if (n_count == r_cmp) begin
                            n_ctrl[CB_INT] = 1'b1;
                        end
                    end else begin
                        n_phase = phase_inc;
                    end
                end
            end
            CMD_EXT: n_ctrl[CB_INT] = 1'b1;
            default: n_ctrl = r_ctrl;
        endcase
    end

    always_comb begin
        o_result.read_data        = rd;
        o_result.irq_line         = n_ctrl[CB_INT] & n_ctrl[CB_MASK];
        o_result.playing          = n_ctrl[CB_PLAY];
        o_result.sample_strobe    = strobe;
        o_result.stream_rate_fast = n_ctrl[CB_SFR];
        o_result.dma_rate_slow    = n_ctrl[CB_DFR];
        o_result.volume_left      = n_vol[7:0];
        o_result.volume_right     = n_vol[15:8];
    end

    `ASSERT_CLK(a_strobe_steps_count, i_clk, i_rst_n,
        (i_accept && strobe) |=> (r_count == $past(r_count) + 32'd1))
    `ASSERT_CLK(a_stopped_tick_holds, i_clk, i_rst_n,
        (i_accept && i_item.cmd == CMD_TICK && !r_ctrl[CB_PLAY]) |=>
            ($stable(r_count) && $stable(r_phase)))
    `ASSERT_CLK(a_no_strobe_when_stopped, i_clk, i_rst_n,
        strobe |-> (r_ctrl[CB_PLAY] && i_item.cmd == CMD_TICK))
    `ASSERT_ALWAYS(a_reset_bit_clear, i_clk, (!i_rst_n || !r_ctrl[CB_RESET]))

endmodule

[hdl/audio_interface_sample_counter_core.sv]
// ----------------------------------------------------------------------------
// audio_interface_sample_counter_core
// audio interface register block with a running sample counter
// ----------------------------------------------------------------------------
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser cmd, tdata reg and data
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata result fields
// cfg       in         i_cfg_valid / o_cfg_ready      index, 16-bit period
//
// one word per cycle while s_axis_tready is high: state updates in one pass at acceptance
// and the result is registered into the output register together with that state update
// the output register lets the next word in while the sink drains the current one
// a stalled sink with a full output register holds s_axis_tready low
// synchronous active-low reset, config port is always ready
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module audio_interface_sample_counter_core
    import aisc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // reg_index[1:0], write_data[33:2], zero fill
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // read_data[31:0], irq_line[32], playing[33],
                                        // sample_strobe[34], stream_rate_fast[35],
                                        // dma_rate_slow[36], volume_left[44:37],
                                        // volume_right[52:45], zero fill
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_period_fast;
    logic [15:0] r_period_slow;
    logic        r_out_valid;
    t_result     r_out;

    logic        accept;
    t_item       item;
    t_result     result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_fast <= PERIOD_FAST_RESET;
            r_period_slow <= PERIOD_SLOW_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FAST: r_period_fast <= i_cfg_data;
                CFG_SLOW: r_period_slow <= i_cfg_data;
                default:  r_period_slow <= r_period_slow;
            endcase
        end
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign item.cmd        = t_cmd'(s_axis_tuser);
    assign item.reg_index  = t_reg'(s_axis_tdata[1:0]);
    assign item.write_data = s_axis_tdata[33:2];

    aisc_state u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (item),
        .i_period_fast (r_period_fast),
        .i_period_slow (r_period_slow),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out};

    `ASSERT_CLK(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid |-> s_axis_tready)
    `ASSERT_CLK(a_accept_fills_output, i_clk, i_rst_n, accept |=> m_axis_tvalid)
    `ASSERT_CLK(a_stall_holds_result, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> $stable(r_out))

endmodule
